@@ rtl/ilir_pkg.sv @@
`default_nettype none

package ilir_pkg;

   localparam int DEFAULT_DEPTH      = 64;
   localparam int DEFAULT_DATA_WIDTH = 32;

   localparam int OPCODE_W = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_READ      = 3'd0,
      OP_INSERT    = 3'd1,
      OP_APPEND    = 3'd2,
      OP_REMOVE_AT = 3'd3,
      OP_REMOVE_EQ = 3'd4,
      OP_CLEAR     = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_BOUNDS   = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EVAL,
      FSM_COMMIT
   } state_type;

   typedef struct packed {
      logic eval;
      logic commit;
      logic shift_up;
      logic shift_down;
      logic remove_match;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/ilir_req_if.sv @@
`default_nettype none

interface ilir_req_if;
   logic                         valid;
   logic                         ready;
   logic [ilir_pkg::OPCODE_W-1:0] opcode;
   logic [ilir_pkg::POS_W-1:0]    position;
   logic [ilir_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/ilir_rsp_if.sv @@
`default_nettype none

interface ilir_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ilir_pkg::VALUE_W-1:0]  read_value;
   logic [ilir_pkg::STATUS_W-1:0] status;
   logic [ilir_pkg::COUNT_W-1:0]  count;

   modport source (output valid, output read_value, output status, output count, input ready);
   modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

`default_nettype wire

@@ rtl/ilir_cell.sv @@
`default_nettype none

module ilir_cell #(
   parameter int DATA_WIDTH = ilir_pkg::DEFAULT_DATA_WIDTH,
   parameter int PW         = 8,
   parameter int INDEX      = 0
) (
   input  wire                          clock,
   input  wire ilir_pkg::cell_ctrl_type ctrl,
   input  wire logic [PW-1:0]           pos,
   input  wire logic [PW-1:0]           count,
   input  wire logic [DATA_WIDTH-1:0]   key,
   input  wire logic [DATA_WIDTH-1:0]   left_data,
   input  wire logic [DATA_WIDTH-1:0]   right_data,
   input  wire logic                    found_in,
   output logic [DATA_WIDTH-1:0]        data,
   output logic                         found_out,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   localparam logic [PW-1:0] IDX = PW'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  ge_ff;
   logic                  eq_ff;
   logic                  match_ff;
   logic                  move_down;

   always_ff @(posedge clock) begin
      if (ctrl.eval) begin
         ge_ff    <= (IDX >= pos);
         eq_ff    <= (IDX == pos);
         match_ff <= (data_ff == key) && (IDX < count);
      end
   end

   assign found_out = found_in | match_ff;
   assign move_down = ctrl.remove_match ? found_out : ge_ff;

   always_comb begin
      data_in = data_ff;
      if (ctrl.commit) begin
         if (ctrl.shift_up && ge_ff) begin
            data_in = eq_ff ? key : left_data;
         end else if (ctrl.shift_down && move_down) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = eq_ff ? data_ff : '0;

endmodule

`default_nettype wire

@@ rtl/indexed_list_insert_remove.sv @@
// Ordered list store of DEPTH elements of DATA_WIDTH bits, held in a row of
// cells that shift toward higher or lower positions as elements come and go.
// The req_ch channel carries one request beat: opcode, position and value.
// The rsp_ch channel returns exactly one beat per request: the read value,
// a status (ok, out of bounds, full, not found) and the element count after
// the request. Both channels use a valid/ready handshake.
// A response beat is registered as its request leaves the commit state.
// A new request is accepted in the same cycle that the previous one
// completes. The evaluate state registers per-cell compares; the commit
// state resolves the first-match chain across the cells and shifts them.
// Reset clears the element count and the handshake state; element storage
// is not cleared and is never read above the count.
// If the receiver stalls, the response register holds its beat, the next
// request is evaluated and then waits until the held beat is taken.
`default_nettype none

module indexed_list_insert_remove #(
   parameter int DEPTH      = ilir_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = ilir_pkg::DEFAULT_DATA_WIDTH
) (
   input wire          clock,
   input wire          reset,
   ilir_req_if.sink    req_ch,
   ilir_rsp_if.source  rsp_ch
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;
   localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

   ilir_pkg::state_type  state_ff;
   ilir_pkg::state_type  state_in;
   ilir_pkg::op_type     op_ff;
   logic [ilir_pkg::POS_W-1:0]   pos_ff;
   logic [ilir_pkg::VALUE_W-1:0] val_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;

   logic                           rsp_valid_ff;
   logic [ilir_pkg::VALUE_W-1:0]   rsp_rd_ff;
   ilir_pkg::status_type           rsp_status_ff;
   logic [ilir_pkg::COUNT_W-1:0]   rsp_count_ff;

   ilir_pkg::cell_ctrl_type ctrl;
   ilir_pkg::status_type    status;
   logic                    req_fire;
   logic                    commit_fire;
   logic                    ok;
   logic                    any_found;
   logic [PW-1:0]           pos_p;
   logic [PW-1:0]           cnt_p;
   logic [PW-1:0]           cell_pos;
   logic [DATA_WIDTH-1:0]   key;
   logic [DATA_WIDTH-1:0]   rd_or;

   logic [DATA_WIDTH-1:0] data_w  [DEPTH];
   logic [DATA_WIDTH-1:0] rd_w    [DEPTH];
   logic                  found_w [DEPTH+1];

   assign pos_p    = PW'(pos_ff);
   assign cnt_p    = PW'(count_ff);
   assign key      = DATA_WIDTH'(val_ff);
   assign cell_pos = (op_ff == ilir_pkg::OP_APPEND) ? cnt_p : pos_p;

   assign req_fire    = req_ch.valid && req_ch.ready;
   assign commit_fire = (state_ff == ilir_pkg::FSM_COMMIT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ilir_pkg::FSM_IDLE: begin
            if (req_fire) state_in = ilir_pkg::FSM_EVAL;
         end
         ilir_pkg::FSM_EVAL: begin
            state_in = ilir_pkg::FSM_COMMIT;
         end
         ilir_pkg::FSM_COMMIT: begin
            if (commit_fire) state_in = req_fire ? ilir_pkg::FSM_EVAL : ilir_pkg::FSM_IDLE;
         end
         default: begin
            state_in = ilir_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ch.ready      = (state_ff == ilir_pkg::FSM_IDLE) || commit_fire;
      ctrl.eval         = (state_ff == ilir_pkg::FSM_EVAL);
      ctrl.commit       = commit_fire && ok;
      ctrl.shift_up     = (op_ff == ilir_pkg::OP_INSERT) || (op_ff == ilir_pkg::OP_APPEND);
      ctrl.shift_down   = (op_ff == ilir_pkg::OP_REMOVE_AT) || (op_ff == ilir_pkg::OP_REMOVE_EQ);
      ctrl.remove_match = (op_ff == ilir_pkg::OP_REMOVE_EQ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ilir_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= ilir_pkg::op_type'(req_ch.opcode);
         pos_ff <= req_ch.position;
         val_ff <= req_ch.value;
      end
   end

   assign found_w[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid
         assign left_data = data_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_next
         assign right_data = data_w[i+1];
      end

      ilir_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .PW         (PW),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (cell_pos),
         .count      (cnt_p),
         .key        (key),
         .left_data  (left_data),
         .right_data (right_data),
         .found_in   (found_w[i]),
         .data       (data_w[i]),
         .found_out  (found_w[i+1]),
         .rd_data    (rd_w[i])
      );
   end

   assign any_found = found_w[DEPTH];

   always_comb begin
      rd_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_or = rd_or | rd_w[i];
      end
   end

   always_comb begin
      status = ilir_pkg::ST_OK;
      case (op_ff)
         ilir_pkg::OP_READ: begin
            if (pos_p >= cnt_p) status = ilir_pkg::ST_BOUNDS;
         end
         ilir_pkg::OP_INSERT: begin
            if (pos_p > cnt_p) status = ilir_pkg::ST_BOUNDS;
            else if (cnt_p == DEPTH_P) status = ilir_pkg::ST_FULL;
         end
         ilir_pkg::OP_APPEND: begin
            if (cnt_p == DEPTH_P) status = ilir_pkg::ST_FULL;
         end
         ilir_pkg::OP_REMOVE_AT: begin
            if (pos_p >= cnt_p) status = ilir_pkg::ST_BOUNDS;
         end
         ilir_pkg::OP_REMOVE_EQ: begin
            if (!any_found) status = ilir_pkg::ST_NOTFOUND;
         end
         default: begin
            status = ilir_pkg::ST_OK;
         end
      endcase
   end

   assign ok = (status == ilir_pkg::ST_OK);

   always_comb begin
      count_in = count_ff;
      if (commit_fire && ok) begin
         case (op_ff)
            ilir_pkg::OP_INSERT,
            ilir_pkg::OP_APPEND:    count_in = count_ff + CW'(1);
            ilir_pkg::OP_REMOVE_AT,
            ilir_pkg::OP_REMOVE_EQ: count_in = count_ff - CW'(1);
            ilir_pkg::OP_CLEAR:     count_in = '0;
            default:                count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (commit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit_fire) begin
         rsp_rd_ff     <= (op_ff == ilir_pkg::OP_READ && ok) ?
                          ilir_pkg::VALUE_W'(rd_or) : '0;
         rsp_status_ff <= status;
         rsp_count_ff  <= ilir_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_rd_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.count      = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      PW'(count_ff) <= DEPTH_P)
      else $error("element count above capacity");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ilir_pkg::FSM_EVAL)
      else $error("accepted request did not enter evaluation");

   a_eval_to_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ilir_pkg::FSM_EVAL |=> state_ff == ilir_pkg::FSM_COMMIT)
      else $error("evaluation not followed by commit");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ilir_pkg::ST_FULL |-> PW'(count_ff) == DEPTH_P)
      else $error("full status with room left");

   a_read_value_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rd_ff != '0 |-> rsp_status_ff == ilir_pkg::ST_OK)
      else $error("nonzero read value on a failed request");
`endif

endmodule

`default_nettype wire

@@ dv/ilir_list_checker.sv @@
`timescale 1ns / 1ps

module ilir_list_checker #(
   parameter int DEPTH = ilir_pkg::DEFAULT_DEPTH
) (
   input wire   clock,
   input wire   reset,
   ilir_req_if  req_ch,
   ilir_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending,
   output int   held_count
);

   typedef struct packed {
      logic [ilir_pkg::VALUE_W-1:0] read_value;
      ilir_pkg::status_type         status;
      logic [ilir_pkg::COUNT_W-1:0] count;
   } list_rsp_type;

   logic [ilir_pkg::VALUE_W-1:0] shadow_elems [DEPTH];
   int                           shadow_count = 0;
   int                           error_total = 0;
   list_rsp_type                 expected_rsp_q [$];

   function automatic void shift_in(int slot, logic [ilir_pkg::VALUE_W-1:0] value);
      for (int i = shadow_count; i > slot; i--) shadow_elems[i] = shadow_elems[i-1];
      shadow_elems[slot] = value;
      shadow_count++;
   endfunction

   function automatic void shift_out(int slot);
      shadow_count--;
      for (int i = slot; i < shadow_count; i++) shadow_elems[i] = shadow_elems[i+1];
   endfunction

   function automatic list_rsp_type predict_response(
         logic [ilir_pkg::OPCODE_W-1:0] opcode,
         logic [ilir_pkg::POS_W-1:0]    position,
         logic [ilir_pkg::VALUE_W-1:0]  value);
      list_rsp_type rsp;
      int           match;
      rsp.read_value = '0;
      rsp.status = ilir_pkg::ST_OK;
      match = -1;
      case (opcode)
         ilir_pkg::OP_READ: begin
            if (int'(position) >= shadow_count) rsp.status = ilir_pkg::ST_BOUNDS;
            else rsp.read_value = shadow_elems[int'(position)];
         end
         ilir_pkg::OP_INSERT: begin
            if (int'(position) > shadow_count) rsp.status = ilir_pkg::ST_BOUNDS;
            else if (shadow_count >= DEPTH) rsp.status = ilir_pkg::ST_FULL;
            else shift_in(int'(position), value);
         end
         ilir_pkg::OP_APPEND: begin
            if (shadow_count >= DEPTH) rsp.status = ilir_pkg::ST_FULL;
            else shift_in(shadow_count, value);
         end
         ilir_pkg::OP_REMOVE_AT: begin
            if (int'(position) >= shadow_count) rsp.status = ilir_pkg::ST_BOUNDS;
            else shift_out(int'(position));
         end
         ilir_pkg::OP_REMOVE_EQ: begin
            for (int i = shadow_count - 1; i >= 0; i--) begin
               if (shadow_elems[i] == value) match = i;
            end
            if (match < 0) rsp.status = ilir_pkg::ST_NOTFOUND;
            else shift_out(match);
         end
         ilir_pkg::OP_CLEAR: begin
            for (int i = 0; i < DEPTH; i++) shadow_elems[i] = '0;
            shadow_count = 0;
         end
         default: ;
      endcase
      rsp.count = ilir_pkg::COUNT_W'(shadow_count);
      return rsp;
   endfunction

   always @(posedge clock) begin
      list_rsp_type seen;
      list_rsp_type want;
      if (reset) begin
         shadow_count = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.read_value = rsp_ch.read_value;
            seen.status = ilir_pkg::status_type'(rsp_ch.status);
            seen.count = rsp_ch.count;
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response beat with none expected, actual %h %0d %0d",
                        $time, seen.read_value, seen.status, seen.count);
               error_total++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (seen.read_value !== want.read_value) begin
                  $display("%0t: read_value expected %h actual %h",
                           $time, want.read_value, seen.read_value);
                  error_total++;
               end
               if (seen.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, seen.status);
                  error_total++;
               end
               if (seen.count !== want.count) begin
                  $display("%0t: count expected %0d actual %0d",
                           $time, want.count, seen.count);
                  error_total++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_rsp_q.insert(expected_rsp_q.size(),
                                  predict_response(req_ch.opcode, req_ch.position,
                                                   req_ch.value));
         end
      end
      fail_count <= error_total;
      pending <= expected_rsp_q.size();
      held_count <= shadow_count;
   end

endmodule

@@ dv/tb_indexed_list_insert_remove.sv @@
`timescale 1ns / 1ps

module tb_indexed_list_insert_remove;

   localparam int RANDOM_ITEMS = 1200;
   localparam int STALL_LIMIT  = 2000;
   localparam logic [ilir_pkg::OPCODE_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [ilir_pkg::OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef enum int {
      MIX_GROW,
      MIX_SHRINK,
      MIX_BALANCED
   } mix_type;

   // Cumulative percent cut points for insert, append, read, remove at,
   // remove match and clear; what is left over goes to the unused opcodes.
   localparam int OP_CUT [3][6] = '{
      '{45, 85, 92, 96, 99, 99},
      '{ 8, 16, 30, 62, 96, 98},
      '{20, 40, 60, 78, 95, 97}
   };
   localparam ilir_pkg::op_type OP_SEQ [6] = '{
      ilir_pkg::OP_INSERT, ilir_pkg::OP_APPEND, ilir_pkg::OP_READ,
      ilir_pkg::OP_REMOVE_AT, ilir_pkg::OP_REMOVE_EQ, ilir_pkg::OP_CLEAR
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_off = 1'b0;
   int   fail_count;
   int   pending;
   int   held_count;
   int   idle_cycles = 0;

   always #4 clock = ~clock;

   ilir_req_if req_ch ();
   ilir_rsp_if rsp_ch ();

   indexed_list_insert_remove u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ilir_list_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .held_count (held_count)
   );

   task automatic send_request(input logic [ilir_pkg::OPCODE_W-1:0] opcode,
                               input logic [ilir_pkg::POS_W-1:0] position,
                               input logic [ilir_pkg::VALUE_W-1:0] value);
      req_ch.valid <= 1'b1;
      req_ch.opcode <= opcode;
      req_ch.position <= position;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin
      int                            burst_left;
      int                            gap;
      int                            episode_left;
      int                            pick;
      int                            k;
      mix_type                       mix;
      logic [ilir_pkg::OPCODE_W-1:0] opcode;
      logic [ilir_pkg::POS_W-1:0]    position;
      logic [ilir_pkg::VALUE_W-1:0]  value;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= ilir_pkg::OP_READ;
      req_ch.position <= '0;
      req_ch.value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_request(ilir_pkg::OP_READ, 7'd0, 32'd0);
      send_request(ilir_pkg::OP_REMOVE_AT, 7'd0, 32'd0);
      send_request(ilir_pkg::OP_REMOVE_EQ, 7'd0, 32'd5);
      send_request(ilir_pkg::OP_INSERT, 7'd1, 32'd7);
      send_request(ilir_pkg::OP_INSERT, 7'd0, 32'hFFFF_FFFF);
      send_request(ilir_pkg::OP_APPEND, 7'h7F, 32'd0);
      send_request(ilir_pkg::OP_INSERT, 7'd1, 32'hA5A5_A5A5);
      send_request(ilir_pkg::OP_INSERT, 7'd3, 32'h5A5A_5A5A);
      send_request(ilir_pkg::OP_READ, 7'd0, 32'd0);
      send_request(ilir_pkg::OP_READ, 7'd1, 32'd0);
      send_request(ilir_pkg::OP_READ, 7'd3, 32'd0);
      send_request(ilir_pkg::OP_READ, 7'd4, 32'd0);
      send_request(ilir_pkg::OP_READ, 7'h7F, 32'hFFFF_FFFF);
      send_request(ilir_pkg::OP_REMOVE_EQ, 7'd0, 32'h1234_5678);
      send_request(ilir_pkg::OP_REMOVE_EQ, 7'd0, 32'd0);
      send_request(ilir_pkg::OP_REMOVE_AT, 7'd3, 32'd0);
      send_request(ilir_pkg::OP_REMOVE_AT, 7'd0, 32'd0);
      send_request(OP_UNUSED_LO, 7'd0, 32'hFFFF_FFFF);
      send_request(OP_UNUSED_HI, 7'h40, 32'd0);
      send_request(ilir_pkg::OP_CLEAR, 7'd0, 32'd0);
      send_request(ilir_pkg::OP_CLEAR, 7'd0, 32'd0);
      send_request(ilir_pkg::OP_READ, 7'd0, 32'd0);

      // The first episode favors growth so that the list fills up early.
      mix = MIX_GROW;
      episode_left = $urandom_range(100, 200);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (episode_left == 0) begin
            mix = mix_type'($urandom_range(0, 2));
            episode_left = $urandom_range(100, 200);
         end
         episode_left--;
         pick = $urandom_range(0, 99);
         k = 0;
         while (k < 6 && pick >= OP_CUT[mix][k]) k++;
         if (k == 6) opcode = ilir_pkg::OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         else opcode = OP_SEQ[k];
         if ($urandom_range(0, 19) == 0) begin
            position = ilir_pkg::POS_W'($urandom_range(0, 127));
         end else begin
            position = ilir_pkg::POS_W'($urandom_range(0,
                          held_count + int'(opcode == ilir_pkg::OP_INSERT)));
         end
         pick = $urandom_range(0, 9);
         if (pick < 5 || (opcode == ilir_pkg::OP_REMOVE_EQ && pick < 8)) begin
            value = $urandom_range(0, 7);
         end
         else if (pick == 5) value = 32'hFFFF_FFFF;
         else if (pick == 6) value = '0;
         else value = $urandom;
         send_request(opcode, position, value);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_ch.valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("indexed_list_insert_remove test passed");
      end else begin
         $display("indexed_list_insert_remove test failed");
      end
      $finish;
   end

   // The receiver switches between always ready, half ready and mostly
   // stalled stretches, and goes fully silent while the hold-off is on.
   initial begin
      int stretch;
      int pattern;
      stretch = 0;
      pattern = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            pattern = $urandom_range(0, 2);
            stretch = $urandom_range(10, 60);
         end
         stretch--;
         if (hold_off) rsp_ch.ready <= 1'b0;
         else if (pattern == 0) rsp_ch.ready <= 1'b1;
         else if (pattern == 1) rsp_ch.ready <= 1'($urandom_range(0, 1));
         else rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      repeat (600) @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("indexed_list_insert_remove test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

@@ files.f @@
rtl/ilir_pkg.sv
rtl/ilir_req_if.sv
rtl/ilir_rsp_if.sv
rtl/ilir_cell.sv
rtl/indexed_list_insert_remove.sv
dv/ilir_list_checker.sv
dv/tb_indexed_list_insert_remove.sv
